// ===== hw/rtl/svm_polynomial_kernel_decision_top_assert.svh =====
// Assertion macros for the polynomial kernel decision block
`ifndef SVM_POLYNOMIAL_KERNEL_DECISION_TOP_ASSERT_SVH
`define SVM_POLYNOMIAL_KERNEL_DECISION_TOP_ASSERT_SVH
// same-cycle implication
`define SVMPK_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("svm kernel assertion failed");
// next-cycle implication
`define SVMPK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("svm kernel assertion failed");
`endif

// ===== hw/rtl/svmpk_pkg.sv =====
`timescale 1ns / 1ps
package svmpk_pkg;

   localparam logic [1:0] OP_SV_LOAD   = 2'd0;
   localparam logic [1:0] OP_COEF_LOAD = 2'd1;
   localparam logic [1:0] OP_FEATURE   = 2'd2;

   localparam logic [2:0] REG_BIAS          = 3'd0;
   localparam logic [2:0] REG_GAMMA         = 3'd1;
   localparam logic [2:0] REG_OFFSET        = 3'd2;
   localparam logic [2:0] REG_DEGREE        = 3'd3;
   localparam logic [2:0] REG_ACTIVE        = 3'd4;
   localparam logic [2:0] REG_FEATURE_COUNT = 3'd5;

   localparam logic signed [31:0] Q16_ONE = 32'sd65536;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LD_WR, ST_VEC, ST_RD, ST_MUL, ST_ACC, ST_BASE, ST_POW,
      ST_PW_WB, ST_SQ, ST_SQ_WB, ST_TERM, ST_TERM_WB, ST_OUT
   } state_type;

   typedef struct packed {
      logic        flag;
      logic [31:0] value;
   } sat_type;

   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v > 64'sd2147483647) begin
         r.flag  = 1'b1;
         r.value = 32'h7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         r.flag  = 1'b1;
         r.value = 32'h8000_0000;
      end else begin
         r.flag  = 1'b0;
         r.value = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/svm_polynomial_kernel_decision_top.sv =====
`timescale 1ns / 1ps
// Polynomial-kernel SVM decision unit.
// req channel: tuser = operation; tdata = vector_index, element_index, sample_value,
// coefficient_value; tlast = is_last. Operation 0 loads a support vector element
// (scaled by gamma on the way in), 1 loads a coefficient, 2 writes a feature element.
// A feature request with tlast set runs the evaluation and returns one rsp request:
// tdata = decision value (Q16.16), tuser = saturation flag.
// csr channel writes bias, gamma, offset, degree, active vectors, feature count; always ready.
// An element load writes its store from ST_LD_WR. The power step forms base^degree by
// square-and-multiply over the degree bits. One shared 32x32 multiplier is reused for element
// load scaling, dot products, power steps and terms; each element runs ST_RD, ST_MUL, ST_ACC.
// req_tready is low while an evaluation or an element store write runs. The result sits in an output register;
// a stalled receiver holds the next result in its final step only.
// Reset clears control state and loads register defaults; the stores are not cleared.
module svm_polynomial_kernel_decision_top
   import svmpk_pkg::*;
#(
   parameter int MAX_VECTORS  = 64,
   parameter int MAX_FEATURES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // vector_index, element_index, sample_value, coef, zero pad
   input  logic [1:0]  req_tuser,  // operation
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // decision_value
   output logic [0:0]  rsp_tuser,  // saturated
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   `include "svm_polynomial_kernel_decision_top_assert.svh"

   localparam int VIdxW   = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int FIdxW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int VCntW   = $clog2(MAX_VECTORS + 1);
   localparam int FCntW   = $clog2(MAX_FEATURES + 1);
   localparam int SvDepth = MAX_VECTORS * MAX_FEATURES;
   localparam int SvAddrW = (SvDepth > 1) ? $clog2(SvDepth) : 1;
   localparam int AccW    = 48 + FCntW;
   localparam int SumW    = 33 + VCntW;

   logic signed [31:0] bias_ff, gamma_ff, offset_ff;
   logic [3:0]         degree_ff;
   logic [6:0]         active_ff;
   logic [5:0]         fcount_ff;

   state_type          state_ff, state_in;
   logic [VCntW-1:0]   v_ff, v_in, nv_ff, nv_in, nv_start;
   logic [FCntW-1:0]   e_ff, e_in, nf_ff, nf_in, nf_start;
   logic signed [AccW-1:0] acc_ff, acc_in;
   logic signed [SumW-1:0] sum_ff, sum_in;
   logic signed [31:0] base_ff, base_in, pw_ff, pw_in;
   logic [3:0]         deg_ff, deg_in;
   logic               flag_ff, flag_in;
   logic [SvAddrW-1:0] ld_addr_ff, ld_addr_in, sv_raddr;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_sat_ff, rsp_sat_in;
   logic               sv_we;

   logic [32:0]        sv_mem [SvDepth];
   logic [31:0]        coef_mem [MAX_VECTORS];
   logic [15:0]        feat_mem [MAX_FEATURES];
   logic [32:0]        sv_rd_ff;
   logic signed [31:0] coef_rd_ff;
   logic signed [15:0] feat_rd_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff;
   logic signed [47:0] dot_prod;

   logic               req_accept;
   logic [5:0]         req_vi;
   logic [4:0]         req_ei;
   logic signed [15:0] req_sample;
   logic [31:0]        req_coef;
   logic               vi_ok, ei_ok;
   logic [VIdxW-1:0]   v_idx;
   logic [FIdxW-1:0]   e_idx;
   logic               eval_req, out_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_vi     = req_tdata[5:0];
   assign req_ei     = req_tdata[10:6];
   assign req_sample = req_tdata[26:11];
   assign req_coef   = req_tdata[58:27];
   assign vi_ok      = 32'(req_vi) < 32'(MAX_VECTORS);
   assign ei_ok      = 32'(req_ei) < 32'(MAX_FEATURES);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign v_idx      = v_ff[VIdxW-1:0];
   assign e_idx      = e_ff[FIdxW-1:0];
   assign sv_raddr   = SvAddrW'(32'(v_idx) * 32'(MAX_FEATURES) + 32'(e_idx));
   assign dot_prod   = prod_ff[47:0];
   assign nv_start   = ({25'd0, active_ff} > 32'(MAX_VECTORS)) ? VCntW'(MAX_VECTORS)
                                                               : VCntW'(active_ff);
   assign nf_start   = ({26'd0, fcount_ff} > 32'(MAX_FEATURES)) ? FCntW'(MAX_FEATURES)
                                                                : FCntW'(fcount_ff);
   assign eval_req   = req_accept && req_tuser == OP_FEATURE && req_tlast;
   assign out_fire   = state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready);

   svmpk_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   always_comb begin
      sat_type s;
      s            = '0;
      state_in     = state_ff;
      v_in         = v_ff;
      e_in         = e_ff;
      nv_in        = nv_ff;
      nf_in        = nf_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      base_in      = base_ff;
      pw_in        = pw_ff;
      deg_in       = deg_ff;
      flag_in      = flag_ff;
      ld_addr_in   = ld_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      sv_we        = 1'b0;
      mul_a        = pw_ff;
      mul_b        = base_ff;
      unique case (state_ff)
         ST_IDLE: begin
            mul_a = 32'(req_sample);
            mul_b = gamma_ff;
            if (req_accept) begin
               case (req_tuser)
                  OP_SV_LOAD: begin
                     if (vi_ok && ei_ok) begin
                        ld_addr_in = SvAddrW'(32'(req_vi) * 32'(MAX_FEATURES) + 32'(req_ei));
                        state_in   = ST_LD_WR;
                     end
                  end
                  OP_FEATURE: begin
                     if (req_tlast) begin
                        sum_in   = SumW'(bias_ff);
                        flag_in  = 1'b0;
                        v_in     = '0;
                        nv_in    = nv_start;
                        nf_in    = nf_start;
                        state_in = (nv_start == '0) ? ST_OUT : ST_VEC;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LD_WR: begin
            sv_we    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_VEC: begin
            acc_in   = '0;
            e_in     = '0;
            state_in = (nf_ff == '0) ? ST_BASE : ST_RD;
         end
         ST_RD: state_in = ST_MUL;
         ST_MUL: begin
            mul_a = signed'(sv_rd_ff[31:0]);
            mul_b = 32'(feat_rd_ff);
            if (sv_rd_ff[32]) flag_in = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff + AccW'(dot_prod);
            e_in     = e_ff + 1'b1;
            state_in = (e_in == nf_ff) ? ST_BASE : ST_RD;
         end
         ST_BASE: begin
            s        = sat32(round_shift(64'(acc_ff), 12) + 64'(offset_ff));
            base_in  = signed'(s.value);
            flag_in  = flag_ff | s.flag;
            pw_in    = Q16_ONE;
            deg_in   = degree_ff;
            state_in = ST_POW;
         end
         ST_POW: begin
            if (deg_ff == 4'd0) begin
               state_in = ST_TERM;
            end else if (deg_ff[0]) begin
               state_in = ST_PW_WB;
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_PW_WB: begin
            s        = sat32(round_shift(prod_ff, 16));
            pw_in    = signed'(s.value);
            flag_in  = flag_ff | s.flag;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            mul_a  = base_ff;
            deg_in = deg_ff >> 1;
            state_in = (deg_ff[3:1] != 3'd0) ? ST_SQ_WB : ST_POW;
         end
         ST_SQ_WB: begin
            s        = sat32(round_shift(prod_ff, 16));
            base_in  = signed'(s.value);
            flag_in  = flag_ff | s.flag;
            state_in = ST_POW;
         end
         ST_TERM: begin
            mul_a    = coef_rd_ff;
            mul_b    = pw_ff;
            state_in = ST_TERM_WB;
         end
         ST_TERM_WB: begin
            s        = sat32(round_shift(prod_ff, 16));
            sum_in   = sum_ff + SumW'(signed'(s.value));
            flag_in  = flag_ff | s.flag;
            v_in     = v_ff + 1'b1;
            state_in = (v_in == nv_ff) ? ST_OUT : ST_VEC;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               s            = sat32(64'(sum_ff));
               rsp_data_in  = s.value;
               rsp_sat_in   = flag_ff | s.flag;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bias_ff      <= '0;
         gamma_ff     <= Q16_ONE;
         offset_ff    <= '0;
         degree_ff    <= 4'd3;
         active_ff    <= 7'd64;
         fcount_ff    <= 6'd32;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_BIAS:          bias_ff   <= csr_data;
               REG_GAMMA:         gamma_ff  <= csr_data;
               REG_OFFSET:        offset_ff <= csr_data;
               REG_DEGREE:        degree_ff <= csr_data[3:0];
               REG_ACTIVE:        active_ff <= csr_data[6:0];
               REG_FEATURE_COUNT: fcount_ff <= csr_data[5:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      e_ff        <= e_in;
      nv_ff       <= nv_in;
      nf_ff       <= nf_in;
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      base_ff     <= base_in;
      pw_ff       <= pw_in;
      deg_ff      <= deg_in;
      flag_ff     <= flag_in;
      ld_addr_ff  <= ld_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   always_ff @(posedge clock) begin
      sat_type ld;
      ld = sat32(round_shift(prod_ff, 12));
      if (sv_we) sv_mem[ld_addr_ff] <= {ld.flag, ld.value};
      sv_rd_ff <= sv_mem[sv_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_tuser == OP_COEF_LOAD && vi_ok) begin
         coef_mem[VIdxW'(req_vi)] <= req_coef;
      end
      coef_rd_ff <= coef_mem[v_idx];
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_tuser == OP_FEATURE && ei_ok) begin
         feat_mem[FIdxW'(req_ei)] <= req_sample;
      end
      feat_rd_ff <= feat_mem[e_idx];
   end

   `SVMPK_ASSERT_NEXT(a_eval_start, eval_req && nv_start != '0, state_ff == ST_VEC)
   `SVMPK_ASSERT_NOW(a_elem_bound, state_ff == ST_RD || state_ff == ST_MUL, e_ff < nf_ff)
   `SVMPK_ASSERT_NEXT(a_result_out, out_fire, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

// ===== hw/rtl/svmpk_mul.sv =====
`timescale 1ns / 1ps
module svmpk_mul
   import svmpk_pkg::*;
(
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [63:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule
